### design/gtf_pkg.sv
// gtf_pkg: shared widths, register indexes, micro-op program and the
// command/status structs of the gammatone filter channel.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gtf_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int STATE_FRAC_DEF  = 24;

	localparam int HIST_W    = 48;
	localparam int OSC_W     = 32;
	localparam int COEF_W    = 32;
	localparam int OP_W      = 64;
	localparam int PROD_W    = 128;
	localparam int ACC_W     = 67;
	localparam int SQ_W      = 96;
	localparam int ROOT_W    = 48;
	localparam int MEM_W     = 24;
	localparam int ENV_W     = 23;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int THR_W     = 16;
	localparam int DECAY_W   = 31;
	localparam int PC_W      = 5;

	localparam int SH_COEF_BITS = 28;
	localparam int SH_OSC_BITS  = 30;

	localparam logic [OSC_W-1:0] Q30_ONE = 32'h4000_0000;

	localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RECT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ENV_EN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 3'd6;

	typedef enum logic [4:0] {
		SRC_XS, SRC_H0, SRC_H1, SRC_H2, SRC_H3, SRC_OSCQ,
		SRC_C0, SRC_C1, SRC_C2, SRC_C3, SRC_C4,
		SRC_UR, SRC_UI, SRC_M, SRC_ROOT, SRC_GAIN, SRC_COS, SRC_SIN,
		SRC_ORE, SRC_OIM, SRC_DA, SRC_A2, SRC_A3
	} src_t;

	typedef enum logic [1:0] {SH_COEF, SH_OSC, SH_OUT, SH_RAW} sh_t;

	typedef enum logic [2:0] {ACC_LOAD, ACC_ADD, ACC_SUB, SQ_LOAD, SQ_ADD} accop_t;

	typedef enum logic [3:0] {
		POST_NONE, POST_P0, POST_U, POST_M, POST_MEM, POST_SQRT, POST_ENV,
		POST_NC, POST_OSC, POST_A2, POST_A3, POST_A4
	} post_t;

	typedef struct packed {
		src_t   a;
		src_t   b;
		sh_t    sh;
		accop_t op;
		post_t  post;
		logic   ch;
	} uop_t;

	localparam logic [PC_W-1:0] PC_SAMPLE      = 5'd0;
	localparam logic [PC_W-1:0] PC_SQ_FIRST    = 5'd17;
	localparam logic [PC_W-1:0] PC_OSC_FIRST   = 5'd20;
	localparam logic [PC_W-1:0] PC_SAMPLE_LAST = 5'd23;
	localparam logic [PC_W-1:0] PC_DERIVE      = 5'd24;
	localparam logic [PC_W-1:0] PC_DERIVE_LAST = 5'd26;

	typedef struct packed {
		logic            accept;
		logic            mul_start;
		logic            acc_en;
		logic            post_en;
		logic            sqrt_start;
		logic            load_out;
		logic [PC_W-1:0] pc;
	} gtf_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic sqrt_done;
		logic env_en;
	} gtf_sts_t;

	// per-sample program, then coefficient derivation
	function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			5'd0:  u = '{SRC_XS,   SRC_OSCQ, SH_OSC,  ACC_LOAD, POST_NONE, 1'b0};
			5'd1:  u = '{SRC_H0,   SRC_C0,   SH_COEF, ACC_ADD,  POST_NONE, 1'b0};
			5'd2:  u = '{SRC_H1,   SRC_C1,   SH_COEF, ACC_ADD,  POST_NONE, 1'b0};
			5'd3:  u = '{SRC_H2,   SRC_C2,   SH_COEF, ACC_ADD,  POST_NONE, 1'b0};
			5'd4:  u = '{SRC_H3,   SRC_C3,   SH_COEF, ACC_ADD,  POST_P0,   1'b0};
			5'd5:  u = '{SRC_H0,   SRC_C0,   SH_COEF, ACC_ADD,  POST_NONE, 1'b0};
			5'd6:  u = '{SRC_H1,   SRC_C4,   SH_COEF, ACC_ADD,  POST_U,    1'b0};
			5'd7:  u = '{SRC_XS,   SRC_OSCQ, SH_OSC,  ACC_LOAD, POST_NONE, 1'b1};
			5'd8:  u = '{SRC_H0,   SRC_C0,   SH_COEF, ACC_ADD,  POST_NONE, 1'b1};
			5'd9:  u = '{SRC_H1,   SRC_C1,   SH_COEF, ACC_ADD,  POST_NONE, 1'b1};
			5'd10: u = '{SRC_H2,   SRC_C2,   SH_COEF, ACC_ADD,  POST_NONE, 1'b1};
			5'd11: u = '{SRC_H3,   SRC_C3,   SH_COEF, ACC_ADD,  POST_P0,   1'b1};
			5'd12: u = '{SRC_H0,   SRC_C0,   SH_COEF, ACC_ADD,  POST_NONE, 1'b1};
			5'd13: u = '{SRC_H1,   SRC_C4,   SH_COEF, ACC_ADD,  POST_U,    1'b1};
			5'd14: u = '{SRC_UR,   SRC_ORE,  SH_OSC,  ACC_LOAD, POST_NONE, 1'b0};
			5'd15: u = '{SRC_UI,   SRC_OIM,  SH_OSC,  ACC_ADD,  POST_M,    1'b0};
			5'd16: u = '{SRC_M,    SRC_GAIN, SH_OUT,  ACC_LOAD, POST_MEM,  1'b0};
			5'd17: u = '{SRC_UR,   SRC_UR,   SH_RAW,  SQ_LOAD,  POST_NONE, 1'b0};
			5'd18: u = '{SRC_UI,   SRC_UI,   SH_RAW,  SQ_ADD,   POST_SQRT, 1'b0};
			5'd19: u = '{SRC_ROOT, SRC_GAIN, SH_OUT,  ACC_LOAD, POST_ENV,  1'b0};
			5'd20: u = '{SRC_COS,  SRC_ORE,  SH_OSC,  ACC_LOAD, POST_NONE, 1'b0};
			5'd21: u = '{SRC_SIN,  SRC_OIM,  SH_OSC,  ACC_ADD,  POST_NC,   1'b0};
			5'd22: u = '{SRC_COS,  SRC_OIM,  SH_OSC,  ACC_LOAD, POST_NONE, 1'b0};
			5'd23: u = '{SRC_SIN,  SRC_ORE,  SH_OSC,  ACC_SUB,  POST_OSC,  1'b0};
			5'd24: u = '{SRC_DA,   SRC_DA,   SH_OSC,  ACC_LOAD, POST_A2,   1'b0};
			5'd25: u = '{SRC_A2,   SRC_DA,   SH_OSC,  ACC_LOAD, POST_A3,   1'b0};
			5'd26: u = '{SRC_A3,   SRC_DA,   SH_OSC,  ACC_LOAD, POST_A4,   1'b0};
			default: u = '{SRC_XS, SRC_XS,   SH_RAW,  ACC_LOAD, POST_NONE, 1'b0};
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

### design/gammatone_filter_channel.sv
// gammatone_filter_channel: top level of one fourth-order complex
// gammatone channel. Depends on gtf_pkg, gtf_ctrl, gtf_datapath.
//
// Input beats (sample, frame_start) use in_valid/in_ready; result beats
// (membrane, envelope) use out_valid/out_ready. frame_start clears the
// filter history and returns the oscillator to angle zero before the
// sample is used. Registers are written through cfg_we/cfg_index/cfg_data.
// All products run through one shared 32x32 multiplier, four partial
// products per product; the root unit runs only with the envelope on.
// One sample is in flight at a time. Writing decay_a queues a
// coefficient derivation, run before the next sample is taken.
// The result sits in an output register: a new sample is accepted while
// it waits, and that sample's result is held back until out_ready takes
// the previous one. Reset restores the register defaults, clears the
// history and coefficients and leaves no result pending.
`timescale 1ns / 1ps
`default_nettype none
module gammatone_filter_channel
	import gtf_pkg::*;
#(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int STATE_FRAC_BITS = STATE_FRAC_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic                          frame_start,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [MEM_W-1:0]            membrane,
	output logic [ENV_W-1:0]                   envelope,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_W-1:0]              cfg_data
);

	gtf_cmd_t cmd;
	gtf_sts_t sts;

	gtf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.sts       (sts),
		.cmd       (cmd)
	);

	gtf_datapath #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.STATE_FRAC_BITS (STATE_FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.sample      (sample),
		.frame_start (frame_start),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.membrane    (membrane),
		.envelope    (envelope)
	);

	// busy right after a beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again straight after a beat");

	// operands are not latched in the cycle the sample is captured
	a_no_start_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !cmd.mul_start && !cmd.acc_en && !cmd.post_en)
		else $error("datapath work issued while sample is captured");

	// multiplier completion is a single-cycle pulse
	a_mul_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |=> !sts.mul_done)
		else $error("multiplier done held for more than one cycle");

endmodule
`default_nettype wire

### design/gtf_mulq.sv
// gtf_mulq: sequential signed multiply, four 32x32 partial products,
// then round half away from zero at a selected shift, capped at 2^62.
// Depends on gtf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gtf_mulq
	import gtf_pkg::*;
#(
	parameter int OUT_SHIFT = 48
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic signed [OP_W-1:0] a,
	input  wire logic signed [OP_W-1:0] b,
	input  wire sh_t                    sh,
	output logic                        done,
	output logic signed [OP_W-1:0]      res,
	output logic [PROD_W-1:0]           prod
);

	localparam int HALF_W = OP_W / 2;
	localparam logic [PROD_W:0] MAG_CAP = (PROD_W+1)'(1) << 62;

	logic [OP_W-1:0]     am_q, bm_q;
	logic                neg_q;
	sh_t                 sh_q;
	logic [2:0]          cnt_q;
	logic                busy_q;
	logic [OP_W-1:0]     pp_q;
	logic [1:0]          pos_q;
	logic [PROD_W-1:0]   prod_q;
	logic signed [OP_W-1:0] res_q;
	logic                done_q;

	logic [HALF_W-1:0]   ha, hb;
	logic [PROD_W-1:0]   pp_ext;
	logic [PROD_W:0]     tsum, shifted;
	logic [62:0]         mag;
	logic signed [OP_W-1:0] rnd;

	always_comb begin
		ha = cnt_q[1] ? am_q[OP_W-1:HALF_W] : am_q[HALF_W-1:0];
		hb = cnt_q[0] ? bm_q[OP_W-1:HALF_W] : bm_q[HALF_W-1:0];
		case (pos_q)
			2'd1:    pp_ext = {{HALF_W{1'b0}}, pp_q, {HALF_W{1'b0}}};
			2'd2:    pp_ext = {pp_q, {OP_W{1'b0}}};
			default: pp_ext = {{OP_W{1'b0}}, pp_q};
		endcase
	end

	always_comb begin
		case (sh_q)
			SH_COEF: begin
				tsum    = {1'b0, prod_q} + ((PROD_W+1)'(1) << (SH_COEF_BITS - 1));
				shifted = tsum >> SH_COEF_BITS;
			end
			SH_OSC: begin
				tsum    = {1'b0, prod_q} + ((PROD_W+1)'(1) << (SH_OSC_BITS - 1));
				shifted = tsum >> SH_OSC_BITS;
			end
			SH_OUT: begin
				tsum    = {1'b0, prod_q} + ((PROD_W+1)'(1) << (OUT_SHIFT - 1));
				shifted = tsum >> OUT_SHIFT;
			end
			default: begin
				tsum    = '0;
				shifted = '0;
			end
		endcase
		mag = (shifted > MAG_CAP) ? MAG_CAP[62:0] : shifted[62:0];
		rnd = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			am_q   <= a[OP_W-1] ? OP_W'(-a) : OP_W'(a);
			bm_q   <= b[OP_W-1] ? OP_W'(-b) : OP_W'(b);
			neg_q  <= a[OP_W-1] ^ b[OP_W-1];
			sh_q   <= sh;
			prod_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < 3'd4) begin
				pp_q  <= ha * hb;
				pos_q <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
			end
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4)
				prod_q <= prod_q + pp_ext;
			if (cnt_q == 3'd5)
				res_q <= rnd;
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign prod = prod_q;

endmodule
`default_nettype wire

### design/gtf_isqrt.sv
// gtf_isqrt: floor square root of the 96-bit sum of squares, one root
// bit per cycle by restoring digit recurrence.
// Depends on gtf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gtf_isqrt
	import gtf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [SQ_W-1:0]   rad,
	output logic                   done,
	output logic [ROOT_W-1:0]      root
);

	localparam int REM_W = ROOT_W + 4;
	localparam int CNT_W = $clog2(ROOT_W);

	logic [SQ_W-1:0]   rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;

	logic [REM_W-1:0]  rem_sh, trial;

	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
		trial  = REM_W'({root_q, 2'b01});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[SQ_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

### design/gtf_datapath.sv
// gtf_datapath: configuration registers, filter history, oscillator,
// accumulator and result registers around the shared multiplier and root unit.
// Depends on gtf_pkg, gtf_mulq, gtf_isqrt.
`timescale 1ns / 1ps
`default_nettype none
module gtf_datapath
	import gtf_pkg::*;
#(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int STATE_FRAC_BITS = STATE_FRAC_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gtf_cmd_t                      cmd,
	output gtf_sts_t                           sts,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic                          frame_start,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_W-1:0]              cfg_data,
	output logic signed [MEM_W-1:0]            membrane,
	output logic [ENV_W-1:0]                   envelope
);

	localparam int OUT_SHIFT = 32 + STATE_FRAC_BITS - (MEM_W - SAMPLE_BITS);
	localparam logic signed [ACC_W-1:0] H_MAX = (ACC_W'(1) << (HIST_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] H_MIN = -(ACC_W'(1) << (HIST_W - 1));
	localparam logic signed [ACC_W-1:0] O_MAX = (ACC_W'(1) << (OSC_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] O_MIN = -(ACC_W'(1) << (OSC_W - 1));
	localparam logic signed [ACC_W-1:0] M_MAX = (ACC_W'(1) << (MEM_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] M_MIN = -(ACC_W'(1) << (MEM_W - 1));
	localparam logic signed [ACC_W-1:0] E_MAX = (ACC_W'(1) << ENV_W) - ACC_W'(1);

	// configuration
	logic [DECAY_W-1:0]       decay_q;
	logic [CFG_W-1:0]         gain_q;
	logic signed [OSC_W-1:0]  cos_q, sin_q;
	logic                     rect_q, enven_q;
	logic [THR_W-1:0]         thr_q;

	// state
	logic signed [HIST_W-1:0] hr_q [4];
	logic signed [HIST_W-1:0] hi_q [4];
	logic signed [OSC_W-1:0]  ore_q, oim_q;
	logic signed [COEF_W-1:0] coef_q [5];
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [HIST_W-1:0] p0_q, ur_q, ui_q;
	logic signed [OP_W-1:0]   m_q;
	logic signed [OSC_W-1:0]  nc_q, a2_q, a3_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [SQ_W-1:0]          sq_q;
	logic signed [MEM_W-1:0]  mem_q, membrane_q;
	logic [ENV_W-1:0]         env_q, envelope_q;

	uop_t                     u;
	logic signed [OP_W-1:0]   xs, opa, opb, mres;
	logic [PROD_W-1:0]        mprod;
	logic                     mdone, rdone;
	logic [ROOT_W-1:0]        root;
	logic [DECAY_W-1:0]       da;
	logic signed [ACC_W-1:0]  rext;
	logic signed [HIST_W-1:0] p0v, uv;
	logic [HIST_W-1:0]        p0mag;
	logic signed [MEM_W-1:0]  mv;
	logic [COEF_W+2:0]        six_a2;

	function automatic logic signed [HIST_W-1:0] sat_h(logic signed [ACC_W-1:0] v);
		if (v > H_MAX) return H_MAX[HIST_W-1:0];
		if (v < H_MIN) return H_MIN[HIST_W-1:0];
		return v[HIST_W-1:0];
	endfunction

	function automatic logic signed [OSC_W-1:0] sat_o(logic signed [ACC_W-1:0] v);
		if (v > O_MAX) return O_MAX[OSC_W-1:0];
		if (v < O_MIN) return O_MIN[OSC_W-1:0];
		return v[OSC_W-1:0];
	endfunction

	function automatic logic signed [MEM_W-1:0] sat_m(logic signed [ACC_W-1:0] v);
		if (v > M_MAX) return M_MAX[MEM_W-1:0];
		if (v < M_MIN) return M_MIN[MEM_W-1:0];
		return v[MEM_W-1:0];
	endfunction

	function automatic logic signed [OP_W-1:0] operand(src_t s, logic ch);
		case (s)
			SRC_XS:   return xs;
			SRC_H0:   return OP_W'(ch ? hi_q[0] : hr_q[0]);
			SRC_H1:   return OP_W'(ch ? hi_q[1] : hr_q[1]);
			SRC_H2:   return OP_W'(ch ? hi_q[2] : hr_q[2]);
			SRC_H3:   return OP_W'(ch ? hi_q[3] : hr_q[3]);
			SRC_OSCQ: return OP_W'(ch ? oim_q : ore_q);
			SRC_C0:   return OP_W'(coef_q[0]);
			SRC_C1:   return OP_W'(coef_q[1]);
			SRC_C2:   return OP_W'(coef_q[2]);
			SRC_C3:   return OP_W'(coef_q[3]);
			SRC_C4:   return OP_W'(coef_q[4]);
			SRC_UR:   return OP_W'(ur_q);
			SRC_UI:   return OP_W'(ui_q);
			SRC_M:    return m_q;
			SRC_ROOT: return $signed({{(OP_W-ROOT_W){1'b0}}, root});
			SRC_GAIN: return $signed({{(OP_W-CFG_W){1'b0}}, gain_q});
			SRC_COS:  return OP_W'(cos_q);
			SRC_SIN:  return OP_W'(sin_q);
			SRC_ORE:  return OP_W'(ore_q);
			SRC_OIM:  return OP_W'(oim_q);
			SRC_DA:   return $signed({{(OP_W-DECAY_W){1'b0}}, da});
			SRC_A2:   return OP_W'(a2_q);
			SRC_A3:   return OP_W'(a3_q);
			default:  return '0;
		endcase
	endfunction

	always_comb begin
		u    = uop_rom(cmd.pc);
		xs   = $signed({{(OP_W-SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q})
			<<< STATE_FRAC_BITS;
		// pole radius above one is held at one
		da   = (decay_q > DECAY_W'(Q30_ONE)) ? DECAY_W'(Q30_ONE) : decay_q;
		opa  = operand(u.a, u.ch);
		opb  = operand(u.b, u.ch);
		rext = ACC_W'(mres);
		p0v  = sat_h(acc_q);
		p0mag = p0v[HIST_W-1] ? HIST_W'(-p0v) : HIST_W'(p0v);
		uv   = sat_h(acc_q);
		mv   = sat_m(acc_q);
		six_a2 = (COEF_W+3)'(a2_q) * (COEF_W+3)'(6) + (COEF_W+3)'(2);
	end

	gtf_mulq #(.OUT_SHIFT(OUT_SHIFT)) u_mulq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (opa),
		.b      (opb),
		.sh     (u.sh),
		.done   (mdone),
		.res    (mres),
		.prod   (mprod)
	);

	gtf_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.rad    (sq_q),
		.done   (rdone),
		.root   (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= '0;
			gain_q  <= '0;
			cos_q   <= Q30_ONE;
			sin_q   <= '0;
			rect_q  <= 1'b0;
			enven_q <= 1'b0;
			thr_q   <= THR_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DECAY:  decay_q <= cfg_data[DECAY_W-1:0];
				CFG_GAIN:   gain_q  <= cfg_data;
				CFG_COS:    cos_q   <= cfg_data;
				CFG_SIN:    sin_q   <= cfg_data;
				CFG_RECT:   rect_q  <= cfg_data[0];
				CFG_ENV_EN: enven_q <= cfg_data[0];
				CFG_THRESH: thr_q   <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				hr_q[k] <= '0;
				hi_q[k] <= '0;
			end
			for (int k = 0; k < 5; k++)
				coef_q[k] <= '0;
			ore_q <= Q30_ONE;
			oim_q <= '0;
		end else begin
			if (cmd.accept && frame_start) begin
				for (int k = 0; k < 4; k++) begin
					hr_q[k] <= '0;
					hi_q[k] <= '0;
				end
				ore_q <= Q30_ONE;
				oim_q <= '0;
			end
			if (cmd.post_en) begin
				case (u.post)
					POST_U: begin
						if (u.ch)
							hi_q <= '{p0_q, hi_q[0], hi_q[1], hi_q[2]};
						else
							hr_q <= '{p0_q, hr_q[0], hr_q[1], hr_q[2]};
					end
					POST_OSC: begin
						ore_q <= nc_q;
						oim_q <= sat_o(acc_q);
					end
					POST_A4: begin
						coef_q[0] <= COEF_W'(da);
						coef_q[1] <= -$signed(COEF_W'(six_a2 >> 2));
						coef_q[2] <= a3_q;
						coef_q[3] <= -$signed(COEF_W'((acc_q + ACC_W'(2)) >>> 2));
						coef_q[4] <= $signed(COEF_W'((a2_q + COEF_W'(2)) >>> 2));
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
			env_q    <= '0;
		end
		if (cmd.acc_en) begin
			case (u.op)
				ACC_LOAD: acc_q <= rext;
				ACC_ADD:  acc_q <= acc_q + rext;
				ACC_SUB:  acc_q <= acc_q - rext;
				SQ_LOAD:  sq_q  <= mprod[SQ_W-1:0];
				SQ_ADD:   sq_q  <= sq_q + mprod[SQ_W-1:0];
				default: ;
			endcase
		end
		if (cmd.post_en) begin
			case (u.post)
				POST_P0: begin
					// small recursion terms are flushed to zero
					if (p0mag < HIST_W'(thr_q)) begin
						p0_q  <= '0;
						acc_q <= '0;
					end else begin
						p0_q  <= p0v;
						acc_q <= ACC_W'(p0v);
					end
				end
				POST_U: begin
					if (u.ch) ui_q <= uv;
					else      ur_q <= uv;
				end
				POST_M:   m_q <= acc_q[OP_W-1:0];
				POST_MEM: mem_q <= (rect_q && mv < 0) ? '0 : mv;
				POST_ENV: begin
					if (!enven_q || acc_q < 0) env_q <= '0;
					else if (acc_q > E_MAX)    env_q <= E_MAX[ENV_W-1:0];
					else                       env_q <= acc_q[ENV_W-1:0];
				end
				POST_NC:  nc_q <= sat_o(acc_q);
				POST_A2:  a2_q <= acc_q[OSC_W-1:0];
				POST_A3:  a3_q <= acc_q[OSC_W-1:0];
				default: ;
			endcase
		end
		if (cmd.load_out) begin
			membrane_q <= mem_q;
			envelope_q <= env_q;
		end
	end

	assign sts.mul_done  = mdone;
	assign sts.sqrt_done = rdone;
	assign sts.env_en    = enven_q;
	assign membrane      = membrane_q;
	assign envelope      = envelope_q;

endmodule
`default_nettype wire

### design/gtf_ctrl.sv
// gtf_ctrl: sequencer that steps the micro-op program, handshakes both
// channels and reruns coefficient derivation after a decay write.
// Depends on gtf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gtf_ctrl
	import gtf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire gtf_sts_t             sts,
	output gtf_cmd_t                  cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ISSUE = 6'b000010,
		S_MUL   = 6'b000100,
		S_POST  = 6'b001000,
		S_SQRT  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t          state_q, state_n;
	logic [PC_W-1:0] pc_q, pc_n;
	logic            dirty_q, dirty_clr;
	logic            out_valid_q;
	uop_t            u;

	// step on, skipping the envelope ops when it is off
	function automatic logic [PC_W-1:0] next_pc(logic [PC_W-1:0] pc, logic env_en);
		logic [PC_W-1:0] n;
		n = pc + PC_W'(1);
		if (n == PC_SQ_FIRST && !env_en)
			n = PC_OSC_FIRST;
		return n;
	endfunction

	always_comb begin
		u         = uop_rom(pc_q);
		state_n   = state_q;
		pc_n      = pc_q;
		dirty_clr = 1'b0;
		cmd       = '0;
		cmd.pc    = pc_q;
		in_ready  = (state_q == S_IDLE) && !dirty_q;
		case (state_q)
			S_IDLE: begin
				if (dirty_q) begin
					dirty_clr = 1'b1;
					pc_n      = PC_DERIVE;
					state_n   = S_ISSUE;
				end else if (in_valid) begin
					cmd.accept = 1'b1;
					pc_n       = PC_SAMPLE;
					state_n    = S_ISSUE;
				end
			end
			S_ISSUE: begin
				cmd.mul_start = 1'b1;
				state_n       = S_MUL;
			end
			S_MUL: begin
				if (sts.mul_done) begin
					cmd.acc_en = 1'b1;
					if (u.post != POST_NONE)       state_n = S_POST;
					else if (pc_q == PC_SAMPLE_LAST) state_n = S_OUT;
					else if (pc_q == PC_DERIVE_LAST) state_n = S_IDLE;
					else begin
						pc_n    = next_pc(pc_q, sts.env_en);
						state_n = S_ISSUE;
					end
				end
			end
			S_POST: begin
				cmd.post_en = 1'b1;
				if (u.post == POST_SQRT) begin
					cmd.sqrt_start = 1'b1;
					state_n        = S_SQRT;
				end else if (pc_q == PC_SAMPLE_LAST) state_n = S_OUT;
				else if (pc_q == PC_DERIVE_LAST)     state_n = S_IDLE;
				else begin
					pc_n    = next_pc(pc_q, sts.env_en);
					state_n = S_ISSUE;
				end
			end
			S_SQRT: begin
				if (sts.sqrt_done) begin
					pc_n    = next_pc(pc_q, sts.env_en);
					state_n = S_ISSUE;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			dirty_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			pc_q    <= pc_n;
			if (cfg_we && cfg_index == CFG_DECAY) dirty_q <= 1'b1;
			else if (dirty_clr)                  dirty_q <= 1'b0;
			if (cmd.load_out)                  out_valid_q <= 1'b1;
			else if (out_ready)                out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
